### rtl/qvr_pkg.sv
package qvr_pkg;

    localparam int Q_BITS     = 36;
    localparam int REM_W      = 64;
    localparam int NORM_W     = 65;
    localparam int MAG_W      = REM_W + Q_BITS;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               norm_error;
        logic               saturated;
    } out_t;

    // one vector component on its way through the divider
    typedef struct packed {
        logic               neg;
        logic [REM_W-1:0]   rem;
        logic [Q_BITS-1:0]  sh;
        logic signed [31:0] v;
    } lane_t;

    typedef struct packed {
        logic              err;
        logic [NORM_W-1:0] n2;
        lane_t [2:0]       lane;
    } div_t;

endpackage

### rtl/qvr_front.sv
module qvr_front
    import qvr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  in_t         request,
    input  logic [31:0] norm_floor,
    output logic        out_valid,
    output div_t        out
);

    logic [6:0] valid_reg;

    // stage 0: conjugate applied when operation is set
    logic signed [32:0] q0_reg [4];
    logic signed [31:0] v0_reg [3];
    // stage 1: products for t and squares for the norm
    logic signed [64:0] pa1_reg [3];
    logic signed [64:0] pb1_reg [3];
    logic signed [65:0] sq1_reg [4];
    logic signed [32:0] q1_reg [4];
    logic signed [31:0] v1_reg [3];
    // stage 2: t and norm
    logic signed [65:0] t2_reg [3];
    logic [NORM_W-1:0]  n2_2_reg;
    logic               err2_reg;
    logic signed [32:0] q2_reg [4];
    logic signed [31:0] v2_reg [3];
    // stage 3: split partial products, term 0 = t*w, term 1 added, term 2 subtracted
    logic signed [65:0] lo3_reg [3][3];
    logic signed [66:0] hi3_reg [3][3];
    logic [NORM_W-1:0]  n2_3_reg;
    logic               err3_reg;
    logic signed [31:0] v3_reg [3];
    // stage 4: full terms
    logic signed [99:0] term4_reg [3][3];
    logic [NORM_W-1:0]  n2_4_reg;
    logic               err4_reg;
    logic signed [31:0] v4_reg [3];
    // stage 5: twice the numerator
    logic signed [99:0] num5_reg [3];
    logic [NORM_W-1:0]  n2_5_reg;
    logic               err5_reg;
    logic signed [31:0] v5_reg [3];
    // stage 6
    div_t               out_reg;

    logic signed [32:0] qin [4];
    logic signed [66:0] n2_sum;

    always_comb
    begin
        qin[0] = {request.quat_w[31], request.quat_w};
        qin[1] = {request.quat_x[31], request.quat_x};
        qin[2] = {request.quat_y[31], request.quat_y};
        qin[3] = {request.quat_z[31], request.quat_z};
        if (request.operation)
        begin
            qin[1] = -qin[1];
            qin[2] = -qin[2];
            qin[3] = -qin[3];
        end
        n2_sum = {sq1_reg[0][65], sq1_reg[0]} + {sq1_reg[1][65], sq1_reg[1]}
               + {sq1_reg[2][65], sq1_reg[2]} + {sq1_reg[3][65], sq1_reg[3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        q0_reg    <= qin;
        v0_reg[0] <= request.vec_x;
        v0_reg[1] <= request.vec_y;
        v0_reg[2] <= request.vec_z;

        pa1_reg[0] <= q0_reg[2] * v0_reg[2];
        pb1_reg[0] <= q0_reg[3] * v0_reg[1];
        pa1_reg[1] <= q0_reg[3] * v0_reg[0];
        pb1_reg[1] <= q0_reg[1] * v0_reg[2];
        pa1_reg[2] <= q0_reg[1] * v0_reg[1];
        pb1_reg[2] <= q0_reg[2] * v0_reg[0];
        for (int k = 0; k < 4; k++)
            sq1_reg[k] <= q0_reg[k] * q0_reg[k];
        q1_reg <= q0_reg;
        v1_reg <= v0_reg;

        for (int i = 0; i < 3; i++)
            t2_reg[i] <= {pa1_reg[i][64], pa1_reg[i]} - {pb1_reg[i][64], pb1_reg[i]};
        n2_2_reg <= n2_sum[NORM_W-1:0];
        err2_reg <= n2_sum[NORM_W-1:0] <= {{(NORM_W-32){1'b0}}, norm_floor};
        q2_reg   <= q1_reg;
        v2_reg   <= v1_reg;

        for (int i = 0; i < 3; i++)
        begin
            lo3_reg[i][0] <= signed'({1'b0, t2_reg[i][31:0]}) * q2_reg[0];
            hi3_reg[i][0] <= signed'(t2_reg[i][65:32]) * q2_reg[0];
            lo3_reg[i][1] <= signed'({1'b0, t2_reg[(i+2)%3][31:0]}) * q2_reg[((i+1)%3)+1];
            hi3_reg[i][1] <= signed'(t2_reg[(i+2)%3][65:32]) * q2_reg[((i+1)%3)+1];
            lo3_reg[i][2] <= signed'({1'b0, t2_reg[(i+1)%3][31:0]}) * q2_reg[((i+2)%3)+1];
            hi3_reg[i][2] <= signed'(t2_reg[(i+1)%3][65:32]) * q2_reg[((i+2)%3)+1];
        end
        n2_3_reg <= n2_2_reg;
        err3_reg <= err2_reg;
        v3_reg   <= v2_reg;

        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                term4_reg[i][k] <= ({{33{hi3_reg[i][k][66]}}, hi3_reg[i][k]} <<< 32)
                                 + {{34{lo3_reg[i][k][65]}}, lo3_reg[i][k]};
        n2_4_reg <= n2_3_reg;
        err4_reg <= err3_reg;
        v4_reg   <= v3_reg;

        for (int i = 0; i < 3; i++)
            num5_reg[i] <= (term4_reg[i][0] + term4_reg[i][1] - term4_reg[i][2]) <<< 1;
        n2_5_reg <= n2_4_reg;
        err5_reg <= err4_reg;
        v5_reg   <= v4_reg;

        out_reg.err <= err5_reg;
        out_reg.n2  <= n2_5_reg;
        for (int i = 0; i < 3; i++)
        begin
            logic [MAG_W-1:0] mag;
            mag = num5_reg[i][99] ? MAG_W'(-num5_reg[i]) : MAG_W'(num5_reg[i]);
            out_reg.lane[i].neg <= num5_reg[i][99];
            out_reg.lane[i].rem <= mag[MAG_W-1:Q_BITS];
            out_reg.lane[i].sh  <= mag[Q_BITS-1:0];
            out_reg.lane[i].v   <= v5_reg[i];
        end
    end

    assign out_valid = valid_reg[6];
    assign out       = out_reg;

endmodule

### rtl/qvr_div.sv
module qvr_div
    import qvr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  div_t in,
    output logic out_valid,
    output div_t out
);

    logic [Q_BITS-1:0] valid_reg;
    div_t              stage_reg [Q_BITS];
    div_t              stage_next [Q_BITS];

    // restoring division, one quotient bit per stage; numerator bits shift
    // out of sh while quotient bits shift in
    always_comb
    begin
        for (int s = 0; s < Q_BITS; s++)
        begin
            div_t       src;
            logic [REM_W:0] trial;
            logic       ge;
            src = (s == 0) ? in : stage_reg[(s == 0) ? 0 : s - 1];
            stage_next[s] = src;
            for (int i = 0; i < 3; i++)
            begin
                trial = {src.lane[i].rem, src.lane[i].sh[Q_BITS-1]};
                ge    = trial >= src.n2;
                stage_next[s].lane[i].rem = ge ? REM_W'(trial - src.n2) : trial[REM_W-1:0];
                stage_next[s].lane[i].sh  = {src.lane[i].sh[Q_BITS-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[Q_BITS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg[Q_BITS-1];
    assign out       = stage_reg[Q_BITS-1];

endmodule

### rtl/qvr_back.sv
module qvr_back
    import qvr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  div_t in,
    output logic done,
    output out_t result
);

    logic               valid1_reg;
    logic               valid2_reg;
    logic signed [37:0] quo1_reg [3];
    logic signed [31:0] v1_reg [3];
    logic               err1_reg;
    out_t               result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [Q_BITS:0]    qmag;
        logic signed [38:0] sum;
        logic signed [31:0] rot [3];
        logic               sat;

        // round half away from zero on the magnitude
        for (int i = 0; i < 3; i++)
        begin
            qmag = {1'b0, in.lane[i].sh};
            if ({in.lane[i].rem, 1'b0} >= in.n2)
                qmag = qmag + 1'b1;
            quo1_reg[i] <= in.lane[i].neg ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
            v1_reg[i]   <= in.lane[i].v;
        end
        err1_reg <= in.err;

        sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sum = {{7{v1_reg[i][31]}}, v1_reg[i]} + {quo1_reg[i][37], quo1_reg[i]};
            if (sum > 39'sh007FFFFFFF)
            begin
                rot[i] = 32'sh7FFFFFFF;
                sat    = 1'b1;
            end
            else if (sum < -39'sh0080000000)
            begin
                rot[i] = 32'sh80000000;
                sat    = 1'b1;
            end
            else
                rot[i] = sum[31:0];
        end
        if (err1_reg)
        begin
            result_reg <= '{rot_x: '0, rot_y: '0, rot_z: '0, norm_error: 1'b1,
                            saturated: 1'b0};
        end
        else
        begin
            result_reg <= '{rot_x: rot[0], rot_y: rot[1], rot_z: rot[2], norm_error: 1'b0,
                            saturated: sat};
        end
    end

    assign done   = valid2_reg;
    assign result = result_reg;

endmodule

### rtl/quaternion_vector_rotate_top.sv
// quaternion vector rotation, signed q16.16 in and out
// an item is taken at each rising edge with start high and busy low; busy
// is always low, so a new item may enter in every cycle
// request carries the direction bit, the quaternion and the vector; the
// quaternion need not have unit length, it is divided out by its squared norm
// the result appears on result with done high for exactly one cycle,
// once the item has passed 45 register stages, the first loaded at the
// edge that took it: 7 of multiply and sum,
// 36 for the pipelined restoring divider (one quotient bit per stage),
// and 2 of rounding and clipping
// throughput is one item per cycle, in order, with no gaps added
// the receiver cannot stall: results are shown once and not held
// norm_floor is written through cfg_valid/cfg_data (cfg_ready is always high);
// the user must do so only while no item is in flight; the block does not check
// a squared norm at or below the floor gives a zero vector with norm_error set
// reset clears all valid bits and sets the floor to zero; items in flight
// are dropped
module quaternion_vector_rotate_top
    import qvr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         request,
    output logic        done,
    output out_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0] floor_reg;
    logic        front_valid;
    div_t        front_out;
    logic        div_valid;
    div_t        div_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            floor_reg <= '0;
        else if (cfg_valid && cfg_ready)
            floor_reg <= cfg_data;
    end

    qvr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .request    (request),
        .norm_floor (floor_reg),
        .out_valid  (front_valid),
        .out        (front_out)
    );

    qvr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in        (front_out),
        .out_valid (div_valid),
        .out       (div_out)
    );

    qvr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .in       (div_out),
        .done     (done),
        .result   (result)
    );

endmodule
